// ===== src/icf_pkg.sv =====
// ----------------------------------------------------------------------------
// icf_pkg: shared types and constants of the integer conversion formatter
// Holds the word types of both channels, the conversion codes, the character
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package icf_pkg;

    // Input word: one printf-style conversion request.
    typedef struct packed {
        logic [2:0]  conversion;
        logic [63:0] value_magnitude;
        logic        value_negative;
        logic [5:0]  field_width;
        logic [5:0]  precision;
        logic        has_precision;
        logic        flag_left;
        logic        flag_zero;
        logic        flag_plus;
        logic        flag_space;
        logic        flag_alt;
    } t_in_word;

    // Output word: one character of the formatted field.
    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_word;

    // Conversion codes.
    localparam logic [2:0] CONV_SDEC  = 3'd0;
    localparam logic [2:0] CONV_UDEC  = 3'd1;
    localparam logic [2:0] CONV_OCT   = 3'd2;
    localparam logic [2:0] CONV_HEXL  = 3'd3;
    localparam logic [2:0] CONV_HEXU  = 3'd4;
    localparam logic [2:0] CONV_CHAR  = 3'd5;

    // Character codes.
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // Signed decimal magnitudes at or above this limit print as zero.
    localparam logic [63:0] DEC_LIMIT   = 64'd18000000000000000000;
    localparam logic [5:0]  MAX_FIELD   = 6'd63;
    localparam int          EMIT_W      = 7;
    localparam logic [6:0]  MAX_RESULTS = 7'd64;

    // Binary to BCD conversion: 20 decimal digits cover 64 bits.
    localparam int BCD_DIGITS = 20;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int VALUE_W    = 64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load;
        logic dabble;
        logic sweep;
        logic prep;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic bad;
        logic is_char;
        logic is_dec;
        logic dabble_done;
        logic sweep_done;
        logic empty;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

// ===== src/icf_ctrl.sv =====
// ----------------------------------------------------------------------------
// icf_ctrl: sequencing controller of the integer conversion formatter
// Walks a conversion through load, binary to BCD (%d/%u only), digit sweep
// (not %c), layout and emission; it tells the datapath what to do each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire icf_pkg::t_status i_status,
    output icf_pkg::t_cmd        o_cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOAD   = 6'b000010,
        ST_DABBLE = 6'b000100,
        ST_SWEEP  = 6'b001000,
        ST_PREP   = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                priority if (i_status.bad) begin
                    n_state = ST_IDLE;
                end else if (i_status.is_char) begin
                    n_state = ST_PREP;
                end else if (i_status.is_dec) begin
                    n_state = ST_DABBLE;
                end else begin
                    n_state = ST_SWEEP;
                end
            end
            ST_DABBLE: begin
                o_cmd.dabble = 1'b1;
                if (i_status.dabble_done) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = i_status.empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.emit_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    // A conversion that was taken in always reaches the load step next.
    a_capture_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.load)
        else $error("capture not followed by load");

    // Emission ends only on the last character of the field.
    a_emit_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && !i_status.emit_last) |=> o_cmd.emit)
        else $error("emission left early");

    // No new word is taken while a conversion is in flight.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load || o_cmd.dabble || o_cmd.sweep || o_cmd.prep || o_cmd.emit)
        |-> !o_in_ready)
        else $error("ready during conversion");
`endif

endmodule

`default_nettype wire

// ===== src/icf_dp.sv =====
// ----------------------------------------------------------------------------
// icf_dp: datapath of the integer conversion formatter
// Holds the captured request, the shift-and-add-3 binary to BCD converter,
// the digit buffer, the field layout and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module icf_dp #(
    parameter int DIGIT_BUF = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire icf_pkg::t_cmd     i_cmd,
    input  wire icf_pkg::t_in_word i_in_word,
    output icf_pkg::t_status       o_status,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output icf_pkg::t_out_word     o_out_word
);

    localparam int AW    = $clog2(DIGIT_BUF);
    localparam int CNT_W = $clog2(DIGIT_BUF + 1);
    localparam int EW    = icf_pkg::EMIT_W;

    // Captured request and conversion registers.
    icf_pkg::t_in_word         r_item;
    logic [icf_pkg::VALUE_W-1:0] r_work_value;
    logic [icf_pkg::BCD_W-1:0] r_bcd;
    logic [5:0]                r_step;
    logic [CNT_W-1:0]          r_count;

    // Digit buffer and its prefetched read word.
    logic [7:0]    r_digit_buf [DIGIT_BUF];
    logic [7:0]    r_rd_data;
    logic [AW-1:0] r_rd_ptr;

    // Layout boundaries and emission position.
    logic [EW-1:0] r_e1, r_e2, r_e4, r_e5, r_last;
    logic [EW-1:0] r_emit_index;
    logic [7:0]    r_sign_char;

    logic               r_out_valid;
    icf_pkg::t_out_word r_out_word;

    // Request decode.
    logic        is_dec10, is_sdec, is_oct, is_upper, is_char, is_bad, nonzero;
    logic [63:0] twos;
    assign is_sdec  = (r_item.conversion == icf_pkg::CONV_SDEC);
    assign is_dec10 = is_sdec || (r_item.conversion == icf_pkg::CONV_UDEC);
    assign is_oct   = (r_item.conversion == icf_pkg::CONV_OCT);
    assign is_upper = (r_item.conversion == icf_pkg::CONV_HEXU);
    assign is_char  = (r_item.conversion == icf_pkg::CONV_CHAR);
    assign is_bad   = (r_item.conversion > icf_pkg::CONV_CHAR);
    assign nonzero  = (r_item.value_magnitude != 64'd0);
    assign twos     = r_item.value_negative ? (64'd0 - r_item.value_magnitude)
                                            : r_item.value_magnitude;

    // Add 3 to every BCD digit of five or more before the shift.
    logic [icf_pkg::BCD_W-1:0] bcd_adj;
    always_comb begin
        logic [3:0] nib;
        bcd_adj = r_bcd;
        for (int i = 0; i < icf_pkg::BCD_DIGITS; i++) begin
            nib = r_bcd[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
        end
    end

    // Digit extraction: one digit per cycle from the low end.
    logic [3:0]                digit;
    logic [7:0]                digit_char;
    logic [icf_pkg::BCD_W-1:0] bcd_shifted;
    logic [CNT_W-1:0]          count_inc;
    logic                      sweep_done;
    assign digit       = is_oct ? {1'b0, r_bcd[2:0]} : r_bcd[3:0];
    assign digit_char  = (digit < 4'd10) ? icf_pkg::CH_ZERO + 8'(digit)
                       : (is_upper ? icf_pkg::CH_UPPER_A : icf_pkg::CH_LOWER_A)
                         + 8'(digit) - 8'd10;
    assign bcd_shifted = is_oct ? (r_bcd >> 3) : (r_bcd >> 4);
    assign count_inc   = r_count + CNT_W'(1);
    assign sweep_done  = (bcd_shifted == '0) || (count_inc == CNT_W'(DIGIT_BUF));

    // Field layout from the digit count and the flags.
    logic [5:0]    width_c, prec_c;
    logic          has_sign, alt_zero, zero_eff;
    logic [EW-1:0] count_x, prec_zeros, len, pad, total, capped, lsp, zp;
    logic [EW-1:0] e1, e2, e4, e5;
    always_comb begin
        width_c  = (r_item.field_width > icf_pkg::MAX_FIELD) ? icf_pkg::MAX_FIELD
                                                              : r_item.field_width;
        prec_c   = (r_item.precision > icf_pkg::MAX_FIELD) ? icf_pkg::MAX_FIELD
                                                            : r_item.precision;
        count_x  = EW'(r_count);
        has_sign = is_sdec && (r_item.value_negative || r_item.flag_plus
                               || r_item.flag_space);
        alt_zero = is_oct && r_item.flag_alt && nonzero;
        zero_eff = r_item.flag_zero && !is_char && !(is_sdec && r_item.has_precision);
        prec_zeros = (is_sdec && r_item.has_precision && (EW'(prec_c) > count_x))
                   ? EW'(prec_c) - count_x : '0;
        len      = EW'(has_sign) + EW'(alt_zero) + prec_zeros + count_x;
        pad      = (EW'(width_c) > len) ? EW'(width_c) - len : '0;
        total    = len + pad;
        capped   = (total > icf_pkg::MAX_RESULTS) ? icf_pkg::MAX_RESULTS : total;
        lsp      = (!r_item.flag_left && !zero_eff) ? pad : '0;
        zp       = (!r_item.flag_left && zero_eff) ? pad : '0;
        e1       = lsp;
        e2       = e1 + EW'(has_sign);
        e4       = e2 + zp + EW'(alt_zero) + prec_zeros;
        e5       = e4 + count_x;
    end

    // Character at the current position and the output handshake.
    logic       fire, dig_take, out_last;
    logic [7:0] cur_char;
    assign fire     = i_cmd.emit && (!r_out_valid || i_out_ready);
    assign dig_take = fire && (r_emit_index >= r_e4) && (r_emit_index < r_e5);
    assign out_last = (r_emit_index == r_last);
    always_comb begin
        priority if (r_emit_index < r_e1) begin
            cur_char = icf_pkg::CH_SPACE;
        end else if (r_emit_index < r_e2) begin
            cur_char = r_sign_char;
        end else if (r_emit_index < r_e4) begin
            cur_char = icf_pkg::CH_ZERO;
        end else if (r_emit_index < r_e5) begin
            cur_char = r_rd_data;
        end else begin
            cur_char = icf_pkg::CH_SPACE;
        end
    end

    // Digit buffer write and read ports.
    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr, count_m1;
    logic [7:0]    wr_data;
    assign count_m1 = AW'(r_count - CNT_W'(1));
    assign wr_en    = (i_cmd.load && is_char) || i_cmd.sweep;
    assign wr_addr  = i_cmd.sweep ? AW'(r_count) : '0;
    assign wr_data  = i_cmd.sweep ? digit_char : twos[7:0];
    assign rd_en    = i_cmd.prep || dig_take;
    assign rd_addr  = i_cmd.prep ? count_m1 : r_rd_ptr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_digit_buf[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_digit_buf[rd_addr];
        end
    end

    // Payload registers of the conversion.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_word;
        end
        if (i_cmd.load) begin
            if (is_sdec) begin
                r_work_value <= (r_item.value_magnitude >= icf_pkg::DEC_LIMIT)
                              ? 64'd0 : r_item.value_magnitude;
            end else begin
                r_work_value <= twos;
            end
            r_bcd <= is_dec10 ? '0 : icf_pkg::BCD_W'(twos);
        end else if (i_cmd.dabble) begin
            r_bcd        <= {bcd_adj[icf_pkg::BCD_W-2:0],
                             r_work_value[icf_pkg::VALUE_W-1]};
            r_work_value <= r_work_value << 1;
        end else if (i_cmd.sweep) begin
            r_bcd <= bcd_shifted;
        end
        if (i_cmd.prep) begin
            r_e1        <= e1;
            r_e2        <= e2;
            r_e4        <= e4;
            r_e5        <= e5;
            r_last      <= capped - EW'(1);
            r_rd_ptr    <= AW'(r_count - CNT_W'(2));
            r_sign_char <= r_item.value_negative ? icf_pkg::CH_MINUS
                         : r_item.flag_plus ? icf_pkg::CH_PLUS : icf_pkg::CH_SPACE;
        end else if (dig_take) begin
            r_rd_ptr <= r_rd_ptr - AW'(1);
        end
        if (fire) begin
            r_out_word.out_char  <= cur_char;
            r_out_word.last_char <= out_last;
        end
    end

    // Control counters and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= '0;
            r_count      <= '0;
            r_emit_index <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_step  <= '0;
                r_count <= is_char ? CNT_W'(nonzero) : '0;
            end else if (i_cmd.dabble) begin
                r_step <= r_step + 6'd1;
            end else if (i_cmd.sweep) begin
                r_count <= count_inc;
            end
            if (i_cmd.prep) begin
                r_emit_index <= '0;
            end else if (fire) begin
                r_emit_index <= r_emit_index + EW'(1);
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.bad         = is_bad;
        o_status.is_char     = is_char;
        o_status.is_dec      = is_dec10;
        o_status.dabble_done = &r_step;
        o_status.sweep_done  = sweep_done;
        o_status.empty       = (total == '0);
        o_status.emit_last   = fire && out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    // Emission never runs past the last position of the field.
    a_emit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_emit_index <= r_last))
        else $error("emission index past end of field");

    // The digit count never exceeds the buffer.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DIGIT_BUF))
        else $error("digit count beyond buffer");

    // After the BCD conversion every decimal digit is a valid BCD code.
    a_bcd_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.sweep && is_dec10) |-> (r_bcd[3:0] <= 4'd9))
        else $error("invalid BCD digit");
`endif

endmodule

`default_nettype wire

// ===== src/integer_conversion_formatter_top.sv =====
// ----------------------------------------------------------------------------
// integer_conversion_formatter_top: printf-style integer conversion formatter
// Takes one %d/%u/%o/%x/%X/%c request and sends the padded field out one
// character per word, marking the final character.
// ----------------------------------------------------------------------------
// Before the first character, %c passes through load and layout; %o/%x add a
// digit sweep after load, and %d/%u also run the 64-step shift-and-add-3 BCD
// loop between load and sweep. Characters then leave one per cycle while the
// output is not stalled by i_out_ready, up to 64 per field; a new request is
// taken the cycle after the last character enters the output register.
// Synchronous active-low reset clears the controller, counters and output
// valid; the digit buffer is not cleared and is always written before use.
`default_nettype none

module integer_conversion_formatter_top #(
    parameter int DIGIT_BUF = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire icf_pkg::t_in_word  i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output icf_pkg::t_out_word      o_out_word
);

    icf_pkg::t_cmd    cmd;
    icf_pkg::t_status status;

    // Sequencing controller.
    icf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Conversion datapath and output register.
    icf_dp #(
        .DIGIT_BUF (DIGIT_BUF)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
